// ===== src/ssp_pkg.sv =====
// shared types and constants for the sprite screen projection pipeline
// no dependencies
package ssp_pkg;

   localparam int unsigned CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_ADDR_WIDTH  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ADDR_HEIGHT = 3'd4;
   localparam logic [12:0] WIDTH_RESET  = 13'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // dot magnitude below 2^32, cross likewise
   localparam int unsigned DOT_W = 35;
   localparam int unsigned MAG_W = 24;
   localparam int unsigned NUM_W = 49;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
   } cfg_type;

   function automatic logic signed [15:0] clamp16s(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sd32767;
      end else if (v < -64'sd32768) begin
         return -16'sd32768;
      end else begin
         return v[15:0];
      end
   endfunction

endpackage

// ===== src/ssp_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters
module ssp_divider #(
   parameter int unsigned NW = 49,
   parameter int unsigned DW = 24,
   parameter int unsigned TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [NW-1:0] out_quot,
   output logic [DW-1:0] out_rem,
   output logic [TW-1:0] out_tag
);
   logic            valid_ff [NW+1];
   logic [NW-1:0]   num_ff [NW+1];
   logic [DW:0]     rem_ff [NW+1];
   logic [DW-1:0]   den_ff [NW+1];
   logic [TW-1:0]   tag_ff [NW+1];

   always_comb begin
      valid_ff[0] = in_valid;
      num_ff[0]   = in_num;
      rem_ff[0]   = '0;
      den_ff[0]   = in_den;
      tag_ff[0]   = in_tag;
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW+1:0] trial_in;
      logic [DW+1:0] diff_in;
      always_comb begin
         trial_in = {rem_ff[s], num_ff[s][NW-1]};
         diff_in  = trial_in - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            if (!diff_in[DW+1]) begin
               rem_ff[s+1] <= diff_in[DW:0];
               num_ff[s+1] <= {num_ff[s][NW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial_in[DW:0];
               num_ff[s+1] <= {num_ff[s][NW-2:0], 1'b0};
            end
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[NW];
   assign out_quot  = num_ff[NW];
   assign out_rem   = rem_ff[NW][DW-1:0];
   assign out_tag   = tag_ff[NW];
endmodule

// ===== src/ssp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on nothing but its parameters
module ssp_sqrt #(
   parameter int unsigned RW = 24,
   parameter int unsigned TW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [TW-1:0]  in_tag,
   output logic           out_valid,
   output logic [RW-1:0]  out_root,
   output logic [TW-1:0]  out_tag
);
   logic             valid_ff [RW+1];
   logic [2*RW-1:0]  rad_ff  [RW+1];
   logic [RW+1:0]    rem_ff  [RW+1];
   logic [RW-1:0]    root_ff [RW+1];
   logic [TW-1:0]    tag_ff  [RW+1];

   always_comb begin
      valid_ff[0] = in_valid;
      rad_ff[0]   = in_rad;
      rem_ff[0]   = '0;
      root_ff[0]  = '0;
      tag_ff[0]   = in_tag;
   end

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [RW+3:0] trial_in;
      logic [RW+3:0] test_in;
      logic [RW+3:0] diff_in;
      always_comb begin
         trial_in = {rem_ff[s], rad_ff[s][2*RW-1 -: 2]};
         test_in  = {2'b00, root_ff[s], 2'b01};
         diff_in  = trial_in - test_in;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            rad_ff[s+1] <= {rad_ff[s][2*RW-3:0], 2'b00};
            if (trial_in >= test_in) begin
               rem_ff[s+1]  <= diff_in[RW+1:0];
               root_ff[s+1] <= {root_ff[s][RW-2:0], 1'b1};
            end else begin
               rem_ff[s+1]  <= trial_in[RW+1:0];
               root_ff[s+1] <= {root_ff[s][RW-2:0], 1'b0};
            end
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_tag   = tag_ff[RW];
endmodule

// ===== src/sprite_screen_projection.sv =====
// sprite screen projection: front end, sqrt, three divider pipelines, output stage
// depends on ssp_pkg, ssp_sqrt, ssp_divider
// throughput: one beat per cycle; a stalled output freezes the whole pipeline
// the divider chains set the latency, one quotient bit per stage
// synchronous active-high reset clears valid bits and loads 640 x 480
module sprite_screen_projection (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_viewer_x,
   input  logic [15:0] req_viewer_y,
   input  logic signed [15:0] req_facing_x,
   input  logic signed [15:0] req_facing_y,
   input  logic [15:0] req_sprite_x,
   input  logic [15:0] req_sprite_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_perp_distance,
   output logic [15:0] rsp_sprite_size,
   output logic signed [15:0] rsp_screen_left,
   output logic signed [15:0] rsp_screen_top,
   output logic        rsp_not_visible,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [ssp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ssp_pkg::*;

   // side data carried alongside: dot, cross+dot, visible
   localparam int unsigned SIDE_W = DOT_W + 36 + 1;
   localparam int unsigned D2_NW  = 32;
   localparam int unsigned D2_DW  = 16;
   localparam int unsigned LEFT_NW = 49;
   localparam int unsigned LEFT_DW = 35;
   localparam int unsigned T2_W   = 16 + 16 + 1;

   cfg_type cfg_ff;
   logic    adv;

   assign adv        = !(rsp_valid && rsp_stall);
   assign req_stall  = !adv;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= WIDTH_RESET;
         cfg_ff.screen_height <= HEIGHT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            CSR_ADDR_WIDTH:  cfg_ff.screen_width  <= csr_pwdata[12:0];
            CSR_ADDR_HEIGHT: cfg_ff.screen_height <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         CSR_ADDR_WIDTH:  csr_prdata = {19'd0, cfg_ff.screen_width};
         CSR_ADDR_HEIGHT: csr_prdata = {19'd0, cfg_ff.screen_height};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // stage 1: differences
   logic fv_ff [4];
   logic signed [16:0] dx_ff, dy_ff;
   logic signed [15:0] fx_ff, fy_ff;
   always_ff @(posedge clock) begin
      if (reset) fv_ff[0] <= 1'b0;
      else if (adv) fv_ff[0] <= req_valid;
      if (adv) begin
         dx_ff <= $signed({1'b0, req_sprite_x}) - $signed({1'b0, req_viewer_x});
         dy_ff <= $signed({1'b0, req_sprite_y}) - $signed({1'b0, req_viewer_y});
         fx_ff <= req_facing_x;
         fy_ff <= req_facing_y;
      end
   end

   // stage 2: four products and two squares
   logic signed [32:0] pxx_ff, pyy_ff, pxy_ff, pyx_ff;
   logic [31:0] sqx_ff, sqy_ff;
   always_ff @(posedge clock) begin
      if (reset) fv_ff[1] <= 1'b0;
      else if (adv) fv_ff[1] <= fv_ff[0];
      if (adv) begin
         pxx_ff <= fx_ff * dx_ff;
         pyy_ff <= fy_ff * dy_ff;
         pxy_ff <= fx_ff * dy_ff;
         pyx_ff <= fy_ff * dx_ff;
         sqx_ff <= 32'(fx_ff * fx_ff);
         sqy_ff <= 32'(fy_ff * fy_ff);
      end
   end

   // stage 3: sums
   logic signed [DOT_W-1:0] dot_ff, crs_ff;
   logic [32:0] msq_ff;
   always_ff @(posedge clock) begin
      if (reset) fv_ff[2] <= 1'b0;
      else if (adv) fv_ff[2] <= fv_ff[1];
      if (adv) begin
         dot_ff <= DOT_W'(pxx_ff) + DOT_W'(pyy_ff);
         crs_ff <= DOT_W'(pxy_ff) - DOT_W'(pyx_ff);
         msq_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      end
   end

   // stage 4: visibility and cross+dot
   logic signed [DOT_W:0] cpd_ff;
   logic signed [DOT_W-1:0] dot4_ff;
   logic [32:0] msq4_ff;
   logic vis_ff;
   always_ff @(posedge clock) begin
      if (reset) fv_ff[3] <= 1'b0;
      else if (adv) fv_ff[3] <= fv_ff[2];
      if (adv) begin
         vis_ff  <= (dot_ff > 0);
         cpd_ff  <= (DOT_W+1)'(crs_ff) + (DOT_W+1)'(dot_ff);
         dot4_ff <= dot_ff;
         msq4_ff <= msq_ff;
      end
   end

   // square root of msq * 2^16 (fits 48 bits as msq <= 2^30 + 2^30)
   logic [SIDE_W-1:0] sq_tag, sq_otag;
   logic [MAG_W-1:0] mag;
   logic sq_v;
   assign sq_tag = {vis_ff, dot4_ff, 36'(cpd_ff)};
   ssp_sqrt #(.RW(MAG_W), .TW(SIDE_W)) u_sqrt (
      .clock, .reset, .advance(adv),
      .in_valid(fv_ff[3]), .in_rad({msq4_ff[31:0], 16'd0}), .in_tag(sq_tag),
      .out_valid(sq_v), .out_root(mag), .out_tag(sq_otag)
   );

   logic sq_vis;
   logic signed [DOT_W-1:0] sq_dot;
   logic [35:0] sq_cpd;
   assign {sq_vis, sq_dot, sq_cpd} = sq_otag;

   logic [NUM_W-1:0] d1_num;
   logic [MAG_W-1:0] d1_den;
   assign d1_num = sq_vis ? {6'd0, sq_dot[34:0], 8'd0} : '0;
   assign d1_den = (mag == '0) ? MAG_W'(1) : mag;

   logic d1_v;
   logic [NUM_W-1:0] d1_q;
   logic [MAG_W-1:0] d1_r;
   logic [SIDE_W-1:0] d1_tag;
   ssp_divider #(.NW(NUM_W), .DW(MAG_W), .TW(SIDE_W)) u_div_dist (
      .clock, .reset, .advance(adv),
      .in_valid(sq_v), .in_num(d1_num), .in_den(d1_den), .in_tag(sq_otag),
      .out_valid(d1_v), .out_quot(d1_q), .out_rem(d1_r), .out_tag(d1_tag)
   );

   // saturate distance
   logic dv_ff;
   logic [15:0] dist_ff;
   logic [SIDE_W-1:0] dtag_ff;
   always_ff @(posedge clock) begin
      if (reset) dv_ff <= 1'b0;
      else if (adv) dv_ff <= d1_v;
      if (adv) begin
         dist_ff <= (d1_q > NUM_W'(65535)) ? 16'hFFFF : d1_q[15:0];
         dtag_ff <= d1_tag;
      end
   end

   // size divider: height*256 / dist
   logic [D2_NW-1:0] d2_num;
   logic [D2_DW-1:0] d2_den;
   assign d2_num = {11'd0, cfg_ff.screen_height, 8'd0};
   assign d2_den = (dist_ff == 16'd0) ? 16'd1 : dist_ff;

   logic d2_v;
   logic [D2_NW-1:0] d2_q;
   logic [D2_DW-1:0] d2_r;
   logic [SIDE_W+16-1:0] d2_tag;
   ssp_divider #(.NW(D2_NW), .DW(D2_DW), .TW(SIDE_W+16)) u_div_size (
      .clock, .reset, .advance(adv),
      .in_valid(dv_ff), .in_num(d2_num), .in_den(d2_den), .in_tag({dtag_ff, dist_ff}),
      .out_valid(d2_v), .out_quot(d2_q), .out_rem(d2_r), .out_tag(d2_tag)
   );

   logic s_vis;
   logic signed [DOT_W-1:0] s_dot;
   logic [35:0] s_cpd;
   logic [15:0] s_dist;
   assign {s_vis, s_dot, s_cpd, s_dist} = d2_tag;

   // size saturation and left numerator (cpd*width, signed)
   logic zv_ff, zvis_ff;
   logic [15:0] size_ff, zdist_ff;
   logic signed [48:0] lnum_ff;
   logic signed [DOT_W-1:0] zdot_ff;
   always_ff @(posedge clock) begin
      if (reset) zv_ff <= 1'b0;
      else if (adv) zv_ff <= d2_v;
      if (adv) begin
         if (s_dist == 16'd0 || d2_q > D2_NW'(65535)) size_ff <= 16'hFFFF;
         else size_ff <= d2_q[15:0];
         lnum_ff  <= 49'($signed(s_cpd) * $signed({1'b0, cfg_ff.screen_width}));
         zdot_ff  <= s_dot;
         zvis_ff  <= s_vis;
         zdist_ff <= s_dist;
      end
   end

   // floor division via magnitude: q = neg ? -ceil(|n|/d) : n/d
   logic [LEFT_NW-1:0] l_mag;
   logic l_neg;
   assign l_neg = zvis_ff && lnum_ff[48];
   assign l_mag = !zvis_ff ? '0 : (l_neg ? LEFT_NW'(-lnum_ff) : LEFT_NW'(lnum_ff));
   logic [LEFT_DW-1:0] l_den;
   assign l_den = zvis_ff ? {zdot_ff[33:0], 1'b0} : LEFT_DW'(1);

   logic d3_v;
   logic [LEFT_NW-1:0] d3_q;
   logic [LEFT_DW-1:0] d3_r;
   logic [T2_W+16:0] d3_tag;
   ssp_divider #(.NW(LEFT_NW), .DW(LEFT_DW), .TW(T2_W+17)) u_div_left (
      .clock, .reset, .advance(adv),
      .in_valid(zv_ff), .in_num(l_mag), .in_den(l_den),
      .in_tag({l_neg, zvis_ff, size_ff, zdist_ff, cfg_ff.screen_height[12:0], 3'd0}),
      .out_valid(d3_v), .out_quot(d3_q), .out_rem(d3_r), .out_tag(d3_tag)
   );

   logic o_neg, o_vis;
   logic [15:0] o_size, o_dist;
   logic [12:0] o_h;
   logic [2:0] o_pad;
   assign {o_neg, o_vis, o_size, o_dist, o_h, o_pad} = d3_tag;

   // final: signed quotient, subtract half size, clamp
   logic ev_ff, evis_ff;
   logic signed [50:0] fq_ff;
   logic [15:0] esize_ff, edist_ff;
   logic [12:0] eh_ff;
   always_ff @(posedge clock) begin
      if (reset) ev_ff <= 1'b0;
      else if (adv) ev_ff <= d3_v;
      if (adv) begin
         if (o_neg) fq_ff <= -$signed({2'b00, d3_q}) - ((d3_r != '0) ? 51'sd1 : 51'sd0);
         else fq_ff <= $signed({2'b00, d3_q});
         evis_ff  <= o_vis;
         esize_ff <= o_size;
         edist_ff <= o_dist;
         eh_ff    <= o_h;
      end
   end

   logic signed [63:0] left_w, top_w;
   assign left_w = 64'(fq_ff) - 64'(esize_ff[15:1]);
   assign top_w  = (64'($signed({1'b0, eh_ff})) - 64'($signed({1'b0, esize_ff}))) >>> 1;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= ev_ff;
      if (adv) begin
         rsp_not_visible   <= !evis_ff;
         rsp_perp_distance <= evis_ff ? edist_ff : 16'd0;
         rsp_sprite_size   <= evis_ff ? esize_ff : 16'd0;
         rsp_screen_left   <= evis_ff ? clamp16s(left_w) : 16'sd0;
         rsp_screen_top    <= evis_ff ? clamp16s(top_w) : 16'sd0;
      end
   end
endmodule

// ===== src/ssp_checker.sv =====
// port-level checks for sprite_screen_projection, bound to the top level
// depends on sprite_screen_projection
module ssp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_perp_distance,
   input logic [15:0] rsp_sprite_size,
   input logic        rsp_not_visible,
   input logic        csr_pready
);
   a_stall_follow: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall)) else $error("stall mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_perp_distance))
      else $error("output changed under stall");
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_visible |-> rsp_perp_distance == 16'd0 && rsp_sprite_size == 16'd0)
      else $error("hidden sprite has nonzero fields");
   a_ready: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind sprite_screen_projection ssp_checker u_ssp_checker (.*);
